FILE: hdl/isfu_pkg.sv
package isfu_pkg;

    localparam int DEFAULT_MAX_SIDE = 64;
    localparam int RAND_BITS        = 16;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int RAND_W  = 16;
    localparam int E_W     = 15;
    localparam int M_W     = 14;
    localparam int SIDE_W  = 7;
    localparam int TH_W    = 17;
    localparam int CFG_W   = 51;
    localparam int CFG_A_W = 3;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);
    localparam logic [RAND_W-1:0] RAND_MASK  = RAND_W'((64'd1 << RAND_BITS) - 64'd1);

    typedef enum logic [OP_W-1:0] {
        OP_ATTEMPT = 2'd0,
        OP_LOAD    = 2'd1,
        OP_PRESET  = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_SIDE     = 3'd0,
        REG_PERIODIC = 3'd1,
        REG_TH_LOW   = 3'd2,
        REG_TH_MID   = 3'd3,
        REG_TH_HIGH  = 3'd4
    } cfg_reg_t;

endpackage

FILE: hdl/ising_spin_flip_update_top.sv
// Single-spin Metropolis update engine for a square lattice of one-bit spins of up to
// MAX_SIDE by MAX_SIDE sites, with running energy and magnetization totals. One item is
// taken per cycle when the result side keeps up, and each item passes through an input
// stage and then a result register: the lattice rows above, at and below the site are
// read from three row-wide copies of the lattice into the input stage, and the neighbour
// sum, threshold test, row write-back and total update happen as the item moves on from
// there into the result register. A row written by one item is forwarded to the item right behind it. Rows
// never written read as spin down, so the block is usable straight after reset with
// no clearing pass. Configuration is written through cfg_we, cfg_index and cfg_wdata.
module ising_spin_flip_update_top #(
    parameter int MAX_SIDE = isfu_pkg::DEFAULT_MAX_SIDE
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [isfu_pkg::CFG_A_W-1:0]   cfg_index,
    input  logic [isfu_pkg::CFG_W-1:0]     cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [isfu_pkg::OP_W-1:0]      s_op,
    input  logic [isfu_pkg::IDX_W-1:0]     s_row,
    input  logic [isfu_pkg::IDX_W-1:0]     s_col,
    input  logic [isfu_pkg::RAND_W-1:0]    s_rand_req,
    input  logic                           s_spin_value,
    input  logic signed [isfu_pkg::E_W-1:0] s_energy_preset,
    input  logic signed [isfu_pkg::M_W-1:0] s_mag_preset,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_spin_now,
    output logic                           m_flipped,
    output logic                           m_in_range,
    output logic signed [isfu_pkg::E_W-1:0] m_energy,
    output logic signed [isfu_pkg::M_W-1:0] m_magnetization
);

    import isfu_pkg::*;

    localparam int AW = $clog2(MAX_SIDE);
    localparam int CW = (AW + 1 > SIDE_W) ? AW + 1 : SIDE_W;

    typedef struct packed {
        op_t                op;
        logic               ok;
        logic [AW-1:0]      row;
        logic [AW-1:0]      row_up;
        logic [AW-1:0]      row_dn;
        logic [AW-1:0]      col;
        logic [AW-1:0]      col_l;
        logic [AW-1:0]      col_r;
        logic               z_up;
        logic               z_dn;
        logic               z_l;
        logic               z_r;
        logic [RAND_W-1:0]  rnd;
        logic               spin_value;
        logic [E_W-1:0]     e_preset;
        logic [M_W-1:0]     m_preset;
    } stage_t;

    // configuration
    logic [SIDE_W-1:0] side_reg;
    logic              periodic_reg;
    logic [CFG_W-1:0]  th_low_reg;
    logic [CFG_W-1:0]  th_mid_reg;
    logic [CFG_W-1:0]  th_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg     <= SIDE_RESET;
            periodic_reg <= 1'b1;
            th_low_reg   <= '0;
            th_mid_reg   <= '0;
            th_high_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SIDE:     side_reg     <= cfg_wdata[SIDE_W-1:0];
                REG_PERIODIC: periodic_reg <= cfg_wdata[0];
                REG_TH_LOW:   th_low_reg   <= cfg_wdata;
                REG_TH_MID:   th_mid_reg   <= cfg_wdata;
                REG_TH_HIGH:  th_high_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // handshake
    logic   s1_valid_reg;
    logic   m_valid_reg;
    logic   s1_adv;
    logic   s_acc;
    stage_t s1_reg;
    stage_t s1_next;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_acc   = s_valid && s_ready;

    // address decode at the input
    logic [CW-1:0] n_eff;
    logic [CW-1:0] side_ext;
    logic [CW-1:0] r_ext;
    logic [CW-1:0] c_ext;
    logic [CW-1:0] r_inc;
    logic [CW-1:0] c_inc;
    logic [CW-1:0] n_dec;
    logic          r_top;
    logic          r_bot;
    logic          c_lft;
    logic          c_rgt;

    always_comb begin
        side_ext = CW'(side_reg);
        n_eff    = (side_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : side_ext;
        n_dec    = n_eff - CW'(1);
        r_ext    = CW'(s_row);
        c_ext    = CW'(s_col);
        r_inc    = r_ext + CW'(1);
        c_inc    = c_ext + CW'(1);
        r_top    = (r_ext == '0);
        c_lft    = (c_ext == '0);
        r_bot    = (r_inc >= n_eff);
        c_rgt    = (c_inc >= n_eff);

        s1_next.op         = op_t'(s_op);
        s1_next.ok         = (r_ext < n_eff) && (c_ext < n_eff);
        s1_next.row        = r_ext[AW-1:0];
        s1_next.col        = c_ext[AW-1:0];
        s1_next.row_up     = r_top ? n_dec[AW-1:0] : AW'(r_ext - CW'(1));
        s1_next.row_dn     = r_bot ? '0 : r_inc[AW-1:0];
        s1_next.col_l      = c_lft ? n_dec[AW-1:0] : AW'(c_ext - CW'(1));
        s1_next.col_r      = c_rgt ? '0 : c_inc[AW-1:0];
        s1_next.z_up       = !periodic_reg && r_top;
        s1_next.z_dn       = !periodic_reg && r_bot;
        s1_next.z_l        = !periodic_reg && c_lft;
        s1_next.z_r        = !periodic_reg && c_rgt;
        s1_next.rnd        = s_rand_req & RAND_MASK;
        s1_next.spin_value = s_spin_value;
        s1_next.e_preset   = s_energy_preset;
        s1_next.m_preset   = s_mag_preset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_reg <= s1_next;
        end
    end

    // lattice rows, three copies read at the rows above, at and below the site
    logic                wr_en;
    logic [MAX_SIDE-1:0] wr_row;
    logic [MAX_SIDE-1:0] q_up;
    logic [MAX_SIDE-1:0] q_mid;
    logic [MAX_SIDE-1:0] q_dn;

    isfu_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_ram_up (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_reg.row),
        .wdata (wr_row),
        .re    (s_acc),
        .raddr (s1_next.row_up),
        .rdata (q_up)
    );

    isfu_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_ram_mid (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_reg.row),
        .wdata (wr_row),
        .re    (s_acc),
        .raddr (s1_next.row),
        .rdata (q_mid)
    );

    isfu_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_ram_dn (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_reg.row),
        .wdata (wr_row),
        .re    (s_acc),
        .raddr (s1_next.row_dn),
        .rdata (q_dn)
    );

    logic [MAX_SIDE-1:0] row_vld_reg;
    logic                fwd_vld_reg;
    logic [AW-1:0]       fwd_row_reg;
    logic [MAX_SIDE-1:0] fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            fwd_vld_reg <= 1'b0;
        end else if (wr_en) begin
            row_vld_reg[s1_reg.row] <= 1'b1;
            fwd_vld_reg             <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_row_reg  <= s1_reg.row;
            fwd_data_reg <= wr_row;
        end
    end

    // row selection with forwarding of the last written row
    logic [MAX_SIDE-1:0] row_up;
    logic [MAX_SIDE-1:0] row_mid;
    logic [MAX_SIDE-1:0] row_dn;

    always_comb begin
        if (fwd_vld_reg && fwd_row_reg == s1_reg.row_up) begin
            row_up = fwd_data_reg;
        end else begin
            row_up = row_vld_reg[s1_reg.row_up] ? q_up : '0;
        end
        if (fwd_vld_reg && fwd_row_reg == s1_reg.row) begin
            row_mid = fwd_data_reg;
        end else begin
            row_mid = row_vld_reg[s1_reg.row] ? q_mid : '0;
        end
        if (fwd_vld_reg && fwd_row_reg == s1_reg.row_dn) begin
            row_dn = fwd_data_reg;
        end else begin
            row_dn = row_vld_reg[s1_reg.row_dn] ? q_dn : '0;
        end
    end

    // update
    logic signed [E_W-1:0] energy_reg;
    logic signed [M_W-1:0] mag_reg;
    logic signed [E_W-1:0] energy_next;
    logic signed [M_W-1:0] mag_next;

    logic              spin_cur;
    logic signed [3:0] nb_u;
    logic signed [3:0] nb_d;
    logic signed [3:0] nb_l;
    logic signed [3:0] nb_r;
    logic signed [3:0] nb_sum;
    logic signed [3:0] s_sum;
    logic signed [4:0] de;
    logic [3:0]        th_idx;
    logic [TH_W-1:0]   th;
    logic              flip;
    logic              spin_new;
    logic              spin_out;

    always_comb begin
        spin_cur = row_mid[s1_reg.col];
        nb_u     = s1_reg.z_up ? 4'sd0 : (row_up[s1_reg.col]  ? 4'sd1 : -4'sd1);
        nb_d     = s1_reg.z_dn ? 4'sd0 : (row_dn[s1_reg.col]  ? 4'sd1 : -4'sd1);
        nb_l     = s1_reg.z_l  ? 4'sd0 : (row_mid[s1_reg.col_l] ? 4'sd1 : -4'sd1);
        nb_r     = s1_reg.z_r  ? 4'sd0 : (row_mid[s1_reg.col_r] ? 4'sd1 : -4'sd1);
        nb_sum   = nb_u + nb_d + nb_l + nb_r;
        s_sum    = spin_cur ? nb_sum : -nb_sum;
        de       = 5'(s_sum) <<< 1;
        th_idx   = 4'(s_sum + 4'sd4);

        unique case (th_idx)
            4'd0:    th = th_low_reg[0*TH_W +: TH_W];
            4'd1:    th = th_low_reg[1*TH_W +: TH_W];
            4'd2:    th = th_low_reg[2*TH_W +: TH_W];
            4'd3:    th = th_mid_reg[0*TH_W +: TH_W];
            4'd4:    th = th_mid_reg[1*TH_W +: TH_W];
            4'd5:    th = th_mid_reg[2*TH_W +: TH_W];
            4'd6:    th = th_high_reg[0*TH_W +: TH_W];
            4'd7:    th = th_high_reg[1*TH_W +: TH_W];
            4'd8:    th = th_high_reg[2*TH_W +: TH_W];
            default: th = '0;
        endcase

        flip = (s1_reg.op == OP_ATTEMPT) && s1_reg.ok && ({1'b0, s1_reg.rnd} < th);

        if (s1_reg.op == OP_LOAD) begin
            spin_new = s1_reg.spin_value;
        end else begin
            spin_new = flip ? !spin_cur : spin_cur;
        end
        spin_out = s1_reg.ok && spin_new;

        wr_row              = row_mid;
        wr_row[s1_reg.col]  = spin_new;
        wr_en = s1_adv && s1_reg.ok && ((s1_reg.op == OP_LOAD) || flip);

        if (s1_reg.op == OP_PRESET) begin
            energy_next = s1_reg.e_preset;
            mag_next    = s1_reg.m_preset;
        end else if (flip) begin
            energy_next = energy_reg + E_W'(de);
            mag_next    = spin_cur ? mag_reg - M_W'(2) : mag_reg + M_W'(2);
        end else begin
            energy_next = energy_reg;
            mag_next    = mag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= '0;
            mag_reg    <= '0;
        end else if (s1_adv) begin
            energy_reg <= energy_next;
            mag_reg    <= mag_next;
        end
    end

    // result register
    logic m_spin_now_reg;
    logic m_flipped_reg;
    logic m_in_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_spin_now_reg <= spin_out;
            m_flipped_reg  <= flip;
            m_in_range_reg <= s1_reg.ok;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_spin_now      = m_spin_now_reg;
    assign m_flipped       = m_flipped_reg;
    assign m_in_range      = m_in_range_reg;
    assign m_energy        = energy_reg;
    assign m_magnetization = mag_reg;

endmodule

FILE: hdl/isfu_ram.sv
module isfu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/isfu_lattice_mirror_pkg.sv
package isfu_lattice_mirror_pkg;

    import isfu_pkg::*;

    localparam int LATTICE_MAX = DEFAULT_MAX_SIDE;

    typedef struct packed {
        op_t                   op;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic [RAND_W-1:0]     rnd;
        logic                  spin_value;
        logic signed [E_W-1:0] energy_preset;
        logic signed [M_W-1:0] mag_preset;
    } spin_req_t;

    typedef struct packed {
        logic                  spin_now;
        logic                  flipped;
        logic                  in_range;
        logic signed [E_W-1:0] energy;
        logic signed [M_W-1:0] magnetization;
    } spin_res_t;

    class lattice_mirror;
        bit                spins [LATTICE_MAX*LATTICE_MAX];
        logic [E_W-1:0]    energy_sum;
        logic [M_W-1:0]    mag_sum;
        logic [SIDE_W-1:0] side;
        bit                periodic;
        logic [CFG_W-1:0]  th_bank [3];
        spin_res_t         due_spin_results [$];
        int                bad_fields;

        function new();
            energy_sum = '0;
            mag_sum    = '0;
            side       = SIDE_RESET;
            periodic   = 1'b1;
            foreach (th_bank[k]) th_bank[k] = '0;
            bad_fields = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SIDE:     side = val[SIDE_W-1:0];
                REG_PERIODIC: periodic = val[0];
                REG_TH_LOW:   th_bank[0] = val;
                REG_TH_MID:   th_bank[1] = val;
                REG_TH_HIGH:  th_bank[2] = val;
                default: ;
            endcase
        endfunction

        function int used_side();
            return (side > LATTICE_MAX) ? LATTICE_MAX : int'(side);
        endfunction

        function bit spin_at(int r, int c);
            return spins[r*LATTICE_MAX + c];
        endfunction

        // +1, -1, or 0 for a site beyond an open edge
        function int neighbour(int r, int c, int n);
            if (periodic) begin
                if (r < 0) r = n - 1; else if (r >= n) r = 0;
                if (c < 0) c = n - 1; else if (c >= n) c = 0;
            end else if (r < 0 || r >= n || c < 0 || c >= n) begin
                return 0;
            end
            return spins[r*LATTICE_MAX + c] ? 1 : -1;
        endfunction

        function logic [TH_W-1:0] threshold(int idx);
            return TH_W'(th_bank[idx/3] >> (TH_W*(idx%3)));
        endfunction

        function void note_item(spin_req_t q);
            int        n;
            int        r;
            int        c;
            int        a;
            int        s;
            int        nsum;
            int        de;
            bit        ok;
            spin_res_t res;
            n   = used_side();
            r   = int'(q.row);
            c   = int'(q.col);
            a   = r*LATTICE_MAX + c;
            ok  = (r < n) && (c < n);
            res = '0;
            if (q.op == OP_PRESET) begin
                energy_sum = q.energy_preset;
                mag_sum    = q.mag_preset;
            end
            if (ok) begin
                if (q.op == OP_LOAD) spins[a] = q.spin_value;
                if (q.op == OP_ATTEMPT) begin
                    s    = spins[a] ? 1 : -1;
                    nsum = neighbour(r-1, c, n) + neighbour(r+1, c, n)
                         + neighbour(r, c-1, n) + neighbour(r, c+1, n);
                    de   = 2*s*nsum;
                    if ({1'b0, q.rnd} < threshold(s*nsum + 4)) begin
                        spins[a]    = !spins[a];
                        energy_sum  = energy_sum + E_W'(de);
                        mag_sum     = mag_sum - M_W'(2*s);
                        res.flipped = 1'b1;
                    end
                end
                res.spin_now = spins[a];
            end
            res.in_range      = ok;
            res.energy        = energy_sum;
            res.magnetization = mag_sum;
            due_spin_results = {due_spin_results, res};
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            bad_fields++;
            if (bad_fields <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
        endfunction

        function void check_result(spin_res_t got);
            spin_res_t want;
            if (due_spin_results.size() == 0) begin
                flag("unexpected transfer", '0, got);
                return;
            end
            want = due_spin_results.pop_front();
            if (got.spin_now !== want.spin_now)
                flag("spin_now", 32'(want.spin_now), 32'(got.spin_now));
            if (got.flipped !== want.flipped)
                flag("flipped", 32'(want.flipped), 32'(got.flipped));
            if (got.in_range !== want.in_range)
                flag("in_range", 32'(want.in_range), 32'(got.in_range));
            if (got.energy !== want.energy)
                flag("energy", 32'(want.energy), 32'(got.energy));
            if (got.magnetization !== want.magnetization)
                flag("magnetization", 32'(want.magnetization), 32'(got.magnetization));
        endfunction

        function int pending();
            return due_spin_results.size();
        endfunction
    endclass

endpackage

FILE: tb/ising_spin_flip_update_top_test.sv
module ising_spin_flip_update_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import isfu_pkg::*;
    import isfu_lattice_mirror_pkg::*;

    localparam int               HOLD_CYCLES = 250;
    localparam logic [TH_W-1:0]  TH_ONE      = 17'h10000;
    localparam logic [TH_W-1:0]  TH_TOP      = 17'h1FFFF;

    logic                   aclk            = 1'b0;
    logic                   aresetn         = 1'b0;
    logic                   cfg_we          = 1'b0;
    logic [CFG_A_W-1:0]     cfg_index       = '0;
    logic [CFG_W-1:0]       cfg_wdata       = '0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_op            = '0;
    logic [IDX_W-1:0]       s_row           = '0;
    logic [IDX_W-1:0]       s_col           = '0;
    logic [RAND_W-1:0]      s_rand_req      = '0;
    logic                   s_spin_value    = 1'b0;
    logic signed [E_W-1:0]  s_energy_preset = '0;
    logic signed [M_W-1:0]  s_mag_preset    = '0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic                   m_spin_now;
    logic                   m_flipped;
    logic                   m_in_range;
    logic signed [E_W-1:0]  m_energy;
    logic signed [M_W-1:0]  m_magnetization;

    lattice_mirror sb;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_reqs     = 0;

    ising_spin_flip_update_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("** ising_spin_flip_update_top: FAILED **");
        $finish;
    end

    // result side: check each transfer, random stalls, one long hold per request
    initial begin
        spin_res_t got;
        int        holds_served;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_spin_now, m_flipped, m_in_range, m_energy, m_magnetization};
                sb.check_result(got);
            end
            if (holds_served != hold_reqs) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    task automatic send_item(spin_req_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= it.op;
        s_row           <= it.row;
        s_col           <= it.col;
        s_rand_req      <= it.rnd;
        s_spin_value    <= it.spin_value;
        s_energy_preset <= it.energy_preset;
        s_mag_preset    <= it.mag_preset;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
    endtask

    task automatic offer(op_t op, int row, int col, int rnd, bit sv, int ep, int mp);
        spin_req_t it;
        it.op            = op;
        it.row           = IDX_W'(row);
        it.col           = IDX_W'(col);
        it.rnd           = RAND_W'(rnd);
        it.spin_value    = sv;
        it.energy_preset = E_W'(ep);
        it.mag_preset    = M_W'(mp);
        send_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic apply_config(int side_v, bit per, logic [CFG_W-1:0] lo,
                                logic [CFG_W-1:0] mid, logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'({$urandom, $urandom});
        write_reg(REG_SIDE, (junk << SIDE_W) | CFG_W'(side_v));
        write_reg(REG_PERIODIC, (junk << 1) | CFG_W'(per));
        write_reg(REG_TH_LOW, lo);
        write_reg(REG_TH_MID, mid);
        write_reg(REG_TH_HIGH, hi);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pack_th(logic [TH_W-1:0] a, logic [TH_W-1:0] b,
                                                 logic [TH_W-1:0] c);
        return {c, b, a};
    endfunction

    function automatic logic [TH_W-1:0] rand_th();
        case ($urandom_range(4))
            0:       return '0;
            1:       return TH_ONE;
            2:       return TH_TOP;
            3:       return TH_W'($urandom_range(65535));
            default: return TH_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_bank();
        return pack_th(rand_th(), rand_th(), rand_th());
    endfunction

    function automatic spin_req_t random_item();
        spin_req_t it;
        int        n;
        int        pick;
        n    = sb.used_side();
        pick = $urandom_range(99);
        if (pick < 55) it.op = OP_ATTEMPT;
        else if (pick < 78) it.op = OP_LOAD;
        else if (pick < 92) it.op = OP_PRESET;
        else it.op = OP_NONE;
        if (n > 0 && $urandom_range(7) != 0) begin
            it.row = IDX_W'($urandom_range(n - 1));
            it.col = IDX_W'($urandom_range(n - 1));
        end else begin
            it.row = IDX_W'($urandom);
            it.col = IDX_W'($urandom);
        end
        it.rnd           = RAND_W'($urandom);
        it.spin_value    = 1'($urandom);
        it.energy_preset = E_W'(int'($urandom_range(16384)) - 8192);
        it.mag_preset    = M_W'(int'($urandom_range(8192)) - 4096);
        return it;
    endfunction

    task automatic random_run(int count);
        repeat (count) send_item(random_item());
    endtask

    // flip only down sites in raster order so the magnetisation climbs past its top
    task automatic magnetisation_climb(int count);
        int r;
        int c;
        r = 0;
        c = 0;
        while (count > 0 && r < LATTICE_MAX) begin
            if (!sb.spin_at(r, c)) begin
                offer(OP_ATTEMPT, r, c, $urandom, 1'($urandom), 0, 0);
                count--;
            end
            c++;
            if (c == LATTICE_MAX) begin
                c = 0;
                r++;
            end
        end
    endtask

    // a one-site periodic lattice always sees dE = +8, so the energy wraps
    task automatic energy_climb(int count);
        repeat (count) begin
            if ($urandom_range(19) == 0)
                offer(OP_ATTEMPT, 0, $urandom_range(63, 1), $urandom, 0, 0, 0);
            else
                offer(OP_ATTEMPT, 0, 0, $urandom, 0, 0, 0);
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(33, 57);
        @(posedge aclk);

        // reset thresholds never flip
        offer(OP_ATTEMPT, 0, 0, 0, 0, 0, 0);
        drain();
        apply_config(64, 1'b1, pack_th(TH_TOP, 1, 16384), pack_th(32768, 32768, 65535),
                     pack_th(TH_ONE, TH_TOP, TH_ONE));
        offer(OP_LOAD, 0, 0, 0, 1, 0, 0);
        offer(OP_LOAD, 63, 63, 0, 1, 0, 0);
        offer(OP_LOAD, 0, 63, 0, 1, 0, 0);
        offer(OP_LOAD, 63, 0, 0, 0, 0, 0);
        offer(OP_PRESET, 5, 5, 0, 0, 8192, -4096);
        offer(OP_PRESET, 63, 63, 0, 0, -8192, 4096);
        offer(OP_ATTEMPT, 0, 1, 65535, 0, 0, 0);
        offer(OP_ATTEMPT, 63, 63, 0, 0, 0, 0);
        offer(OP_ATTEMPT, 10, 10, 65535, 0, 0, 0);
        offer(OP_ATTEMPT, 10, 10, 0, 0, 0, 0);
        offer(OP_NONE, 63, 0, 0, 1, 0, 0);
        drain();
        // open edges on a small lattice, out-of-range sites
        apply_config(3, 1'b0, pack_th(TH_ONE, TH_ONE, TH_ONE), pack_th(TH_ONE, TH_ONE, TH_ONE),
                     pack_th(TH_ONE, TH_ONE, TH_ONE));
        offer(OP_ATTEMPT, 0, 0, 1234, 0, 0, 0);
        offer(OP_ATTEMPT, 2, 2, 65535, 0, 0, 0);
        offer(OP_LOAD, 63, 0, 0, 1, 0, 0);
        offer(OP_ATTEMPT, 3, 0, 0, 0, 0, 0);
        offer(OP_PRESET, 10, 10, 0, 0, 100, -100);
        offer(OP_NONE, 0, 5, 0, 1, 0, 0);
        drain();
        apply_config(0, 1'b1, rand_bank(), rand_bank(), rand_bank());
        offer(OP_ATTEMPT, 0, 0, 0, 0, 0, 0);
        offer(OP_LOAD, 0, 0, 0, 1, 0, 0);
        drain();
        apply_config(127, 1'b1, rand_bank(), rand_bank(), rand_bank());
        offer(OP_ATTEMPT, 63, 63, $urandom, 0, 0, 0);
        offer(OP_LOAD, 63, 62, 0, 1, 0, 0);
        drain();
        apply_config(1, 1'b1, rand_bank(), rand_bank(), pack_th(0, 0, TH_ONE));
        offer(OP_ATTEMPT, 0, 0, 65535, 0, 0, 0);
        offer(OP_ATTEMPT, 0, 1, 0, 0, 0, 0);
        drain();

        // magnetisation wrap, with a long result hold while the input stays busy
        apply_config(64, 1'b1, pack_th(TH_TOP, TH_TOP, TH_TOP), pack_th(TH_TOP, TH_TOP, TH_TOP),
                     pack_th(TH_TOP, TH_TOP, TH_TOP));
        offer(OP_PRESET, 0, 0, 0, 0, 0, 8000);
        hold_reqs <= hold_reqs + 1;
        magnetisation_climb(200);
        drain();
        apply_config(64, 1'b1, rand_bank(), rand_bank(), rand_bank());
        random_run(200);
        drain();
        apply_config($urandom_range(12, 2), 1'b0, rand_bank(), rand_bank(), rand_bank());
        random_run(100);

        set_idling(57, 33);
        drain();
        apply_config($urandom_range(127, 65), 1'b0, pack_th(TH_TOP, TH_TOP, TH_TOP),
                     pack_th(TH_TOP, TH_TOP, TH_TOP), pack_th(TH_TOP, TH_TOP, TH_TOP));
        random_run(150);
        drain();
        apply_config(0, 1'($urandom), rand_bank(), rand_bank(), rand_bank());
        random_run(40);
        drain();
        apply_config($urandom_range(63, 1), 1'b1, rand_bank(), rand_bank(), rand_bank());
        hold_reqs <= hold_reqs + 1;
        random_run(150);
        drain();
        // energy wrap
        apply_config(1, 1'b1, rand_bank(), rand_bank(), pack_th(rand_th(), rand_th(), TH_ONE));
        offer(OP_PRESET, 0, 0, 0, 0, 16000, int'($urandom_range(8192)) - 4096);
        energy_climb(120);

        set_idling(0, 0);
        drain();
        apply_config(64, 1'b1, '0, '0, '0);
        random_run(80);
        drain();
        apply_config(1, 1'b0, rand_bank(), rand_bank(), rand_bank());
        random_run(50);
        drain();
        apply_config($urandom_range(64, 1), 1'($urandom), rand_bank(), rand_bank(), rand_bank());
        random_run(180);
        drain();
        repeat (8) @(posedge aclk);

        if (sb.bad_fields == 0 && sb.pending() == 0)
            $display("** ising_spin_flip_update_top: PASSED **");
        else
            $display("** ising_spin_flip_update_top: FAILED **");
        $finish;
    end

endmodule

FILE: ising_spin_flip_update_top.f
hdl/isfu_pkg.sv
hdl/isfu_ram.sv
hdl/ising_spin_flip_update_top.sv
tb/isfu_lattice_mirror_pkg.sv
tb/ising_spin_flip_update_top_test.sv
